### rtl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

  // Q2.14 one
  localparam int unsigned QOne = 16384;

  // stages of each divider; the branch and flag pipeline beside them matches
  localparam int DivSteps = 31;

  typedef enum logic [1:0] {
    BrX = 2'd0,
    BrY = 2'd1,
    BrZ = 2'd2,
    BrW = 2'd3
  } branch_e;

  // classified word: radicand plus the three numerators in output order,
  // skipping the component that the scale gives directly
  typedef struct packed {
    logic               bad;
    branch_e            br;
    logic [16:0]        rad;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       bad;
    branch_e    br;
    logic [14:0] quarter;
  } meta_t;

endpackage
`default_nettype wire

### rtl/rotation_matrix_to_quaternion_core.sv
`default_nettype none
// Rotation matrix to quaternion (Shepperd's method) in Q2.14. Push the nine
// rotation entries of a matrix; pop one quaternion (qx, qy, qz, qw) per word,
// in order. The front stage picks the branch (trace, or the largest diagonal
// entry) and forms the radicand and the three off-diagonal numerators; a
// two-word queue decouples it from the back end, a 17-stage square-root
// pipeline followed by three 31-stage dividers in parallel. One word enters
// and one leaves per cycle when neither side stalls; a word accepted passes
// through the front register, the queue, the square root, the dividers and
// the output register to the result ports. bad_input_o flags a non-positive
// radicand, and then all four components read zero. Components saturate to
// 16 bits and are not renormalized.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] e00_i,
  input  wire logic signed [15:0] e01_i,
  input  wire logic signed [15:0] e02_i,
  input  wire logic signed [15:0] e10_i,
  input  wire logic signed [15:0] e11_i,
  input  wire logic signed [15:0] e12_i,
  input  wire logic signed [15:0] e20_i,
  input  wire logic signed [15:0] e21_i,
  input  wire logic signed [15:0] e22_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      qx_o,
  output logic signed [15:0]      qy_o,
  output logic signed [15:0]      qz_o,
  output logic signed [15:0]      qw_o,
  output logic                    bad_input_o
);

  logic  f_valid, q_full, q_empty, q_push, q_pop, load, en;
  item_t f_item, q_item, s_item;
  logic  s_valid;
  logic [16:0] root;
  logic signed [15:0] d0, d1, d2;
  meta_t meta_q [DivSteps];
  meta_t m_in, m_out;
  logic  out_v_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic  bad_q;
  logic signed [15:0] qx_d, qy_d, qz_d, qw_d;
  logic signed [15:0] quarter;

  // front: accept when the front register is free or drains this cycle
  assign full   = f_valid && q_full;
  assign load   = push && !full;
  assign q_push = f_valid && !q_full;

  rmq_front u_front (
    .clk_i, .rst_ni,
    .load_i (load),
    .drain_i(q_push),
    .e00_i, .e01_i, .e02_i, .e10_i, .e11_i, .e12_i, .e20_i, .e21_i, .e22_i,
    .valid_o(f_valid),
    .item_o (f_item)
  );

  rmq_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (q_push),
    .item_i (f_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .item_o (q_item)
  );

  // back end advances as a whole whenever the output register can take a word
  assign en    = !out_v_q || pop;
  assign q_pop = en && !q_empty;

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .en_i   (en),
    .valid_i(q_pop),
    .item_i (q_item),
    .valid_o(s_valid),
    .item_o (s_item),
    .root_o (root)
  );

  rmq_div u_div0 (.clk_i, .en_i(en), .num_i(s_item.n0), .den_i(root), .quo_o(d0));
  rmq_div u_div1 (.clk_i, .en_i(en), .num_i(s_item.n1), .den_i(root), .quo_o(d1));
  rmq_div u_div2 (.clk_i, .en_i(en), .num_i(s_item.n2), .den_i(root), .quo_o(d2));

  // carry branch and flags alongside the dividers
  always_comb begin
    m_in.valid   = s_valid;
    m_in.bad     = s_item.bad;
    m_in.br      = s_item.br;
    m_in.quarter = root[16:2];
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_meta
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (en) begin
        meta_q[k] <= (k == 0) ? m_in : meta_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign m_out   = meta_q[DivSteps-1];
  assign quarter = 16'(m_out.quarter);

  // place the scale/4 component by branch; the rest follow in order
  always_comb begin
    unique case (m_out.br)
      BrX: begin
        qx_d = quarter; qy_d = d0; qz_d = d1; qw_d = d2;
      end
      BrY: begin
        qx_d = d0; qy_d = quarter; qz_d = d1; qw_d = d2;
      end
      BrZ: begin
        qx_d = d0; qy_d = d1; qz_d = quarter; qw_d = d2;
      end
      BrW: begin
        qx_d = d0; qy_d = d1; qz_d = d2; qw_d = quarter;
      end
      default: begin
        qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
      end
    endcase
    if (m_out.bad) begin
      qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= m_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q  <= qx_d;
      qy_q  <= qy_d;
      qz_q  <= qz_d;
      qw_q  <= qw_d;
      bad_q <= m_out.bad;
    end
  end

  assign empty       = !out_v_q;
  assign qx_o        = qx_q;
  assign qy_o        = qy_q;
  assign qz_o        = qz_q;
  assign qw_o        = qw_q;
  assign bad_input_o = bad_q;

endmodule
`default_nettype wire

### rtl/rmq_front.sv
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic               drain_i,
  input  wire logic signed [15:0] e00_i,
  input  wire logic signed [15:0] e01_i,
  input  wire logic signed [15:0] e02_i,
  input  wire logic signed [15:0] e10_i,
  input  wire logic signed [15:0] e11_i,
  input  wire logic signed [15:0] e12_i,
  input  wire logic signed [15:0] e20_i,
  input  wire logic signed [15:0] e21_i,
  input  wire logic signed [15:0] e22_i,
  output logic                    valid_o,
  output item_t                   item_o
);

  logic signed [18:0] a00, a11, a22, one, trace, rad;
  logic signed [16:0] s12m21, s20m02, s01m10, p10p01, p02p20, p21p12;
  item_t item_d, item_q;
  logic  valid_q;

  always_comb begin
    a00    = 19'(e00_i);
    a11    = 19'(e11_i);
    a22    = 19'(e22_i);
    one    = 19'(QOne);
    trace  = a00 + a11 + a22 + one;
    s12m21 = 17'(e12_i) - 17'(e21_i);
    s20m02 = 17'(e20_i) - 17'(e02_i);
    s01m10 = 17'(e01_i) - 17'(e10_i);
    p10p01 = 17'(e10_i) + 17'(e01_i);
    p02p20 = 17'(e02_i) + 17'(e20_i);
    p21p12 = 17'(e21_i) + 17'(e12_i);
    item_d = '0;
    priority if (trace > 19'sd0) begin
      rad       = trace;
      item_d.br = BrW;
      item_d.n0 = s12m21;
      item_d.n1 = s20m02;
      item_d.n2 = s01m10;
    end else if (e00_i > e11_i && e00_i > e22_i) begin
      rad       = one + a00 - a11 - a22;
      item_d.br = BrX;
      item_d.n0 = p10p01;
      item_d.n1 = p02p20;
      item_d.n2 = s12m21;
    end else if (e11_i > e22_i) begin
      rad       = one + a11 - a00 - a22;
      item_d.br = BrY;
      item_d.n0 = p10p01;
      item_d.n1 = p21p12;
      item_d.n2 = s20m02;
    end else begin
      rad       = one + a22 - a00 - a11;
      item_d.br = BrZ;
      item_d.n0 = p02p20;
      item_d.n1 = p21p12;
      item_d.n2 = s01m10;
    end
    item_d.bad = (rad <= 19'sd0);
    item_d.rad = rad[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (drain_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

### rtl/rmq_queue.sv
`default_nettype none
module rmq_queue import rmq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rptr_q];

endmodule
`default_nettype wire

### rtl/rmq_sqrt.sv
`default_nettype none
// one result bit per stage: scale = floor(sqrt(rad * 65536))
module rmq_sqrt import rmq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire item_t item_i,
  output logic       valid_o,
  output item_t      item_o,
  output logic [16:0] root_o
);

  localparam int Steps = 17;

  logic        v_q    [Steps];
  item_t       it_q   [Steps];
  logic [17:0] rem_q  [Steps];
  logic [16:0] root_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Pair = Steps - 1 - k;
    logic        v_in;
    item_t       it_in;
    logic [17:0] rem_in;
    logic [16:0] root_in;
    logic [1:0]  pair;
    logic [19:0] rem_sh;
    logic [19:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign it_in   = item_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign it_in   = it_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // upper pairs come from the radicand, the low ones from the 65536 factor
    if (Pair >= 8) begin : g_rad
      logic [17:0] rad18;
      assign rad18 = {1'b0, it_in.rad};
      assign pair  = rad18[2*(Pair-8) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem_sh = {rem_in, pair};
      trial  = {1'b0, root_in, 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[k]   <= it_in;
        rem_q[k]  <= take ? 18'(rem_sh - trial) : rem_sh[17:0];
        root_q[k] <= {root_in[15:0], take};
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign item_o  = it_q[Steps-1];
  assign root_o  = root_q[Steps-1];

endmodule
`default_nettype wire

### rtl/rmq_div.sv
`default_nettype none
// restoring divider, one quotient bit per stage: sat16((num * 16384) / den)
module rmq_div import rmq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [16:0] num_i,
  input  wire logic [16:0]        den_i,
  output logic signed [15:0]      quo_o
);

  localparam int Steps = DivSteps;

  logic        neg_q [Steps];
  logic [16:0] mag_q [Steps];
  logic [16:0] den_q [Steps];
  logic [16:0] rem_q [Steps];
  logic [30:0] quo_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = Steps - 1 - k;
    logic        neg_in;
    logic [16:0] mag_in, den_in, rem_in;
    logic [30:0] quo_in;
    logic        dbit;
    logic [17:0] rem_sh;
    logic        take;

    if (k == 0) begin : g_first
      assign neg_in = num_i[16];
      assign mag_in = num_i[16] ? 17'(-num_i) : 17'(num_i);
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign neg_in = neg_q[k-1];
      assign mag_in = mag_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // dividend is the magnitude shifted up by 14
    if (Bit >= 14) begin : g_bit
      assign dbit = mag_in[Bit-14];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    always_comb begin
      rem_sh = {rem_in, dbit};
      take   = (rem_sh >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k] <= neg_in;
        mag_q[k] <= mag_in;
        den_q[k] <= den_in;
        rem_q[k] <= take ? 17'(rem_sh - {1'b0, den_in}) : rem_sh[16:0];
        quo_q[k] <= {quo_in[29:0], take};
      end
    end
  end

  always_comb begin
    if (neg_q[Steps-1]) begin
      quo_o = (quo_q[Steps-1] > 31'd32768) ? 16'sh8000 : 16'(-quo_q[Steps-1]);
    end else begin
      quo_o = (quo_q[Steps-1] > 31'd32767) ? 16'sh7fff : 16'(quo_q[Steps-1]);
    end
  end

endmodule
`default_nettype wire

### rtl/rmq_checker.sv
`default_nettype none
module rmq_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic signed [15:0] qx_o,
  input wire logic signed [15:0] qy_o,
  input wire logic signed [15:0] qz_o,
  input wire logic signed [15:0] qw_o,
  input wire logic               bad_input_o
);

  // a waiting word stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result word dropped");

  // flagged words carry zero components
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_input_o) |->
      (qx_o == 16'sd0 && qy_o == 16'sd0 && qz_o == 16'sd0 && qw_o == 16'sd0))
    else $error("bad word with nonzero components");

  // the scale/4 component is at least 64 on a good word
  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !bad_input_o) |->
      (qx_o >= 16'sd64 || qy_o >= 16'sd64 || qz_o >= 16'sd64 || qw_o >= 16'sd64))
    else $error("no scale component on good word");

  // full only rises after an accepted word
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push)) else $error("full without push");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop,
  .qx_o, .qy_o, .qz_o, .qw_o, .bad_input_o
);
`default_nettype wire

### sim/tb_rotation_matrix_to_quaternion_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;
  import rmq_pkg::*;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    logic               bad;
  } quat_t;

  // Predict the quaternion for each matrix and hold expectations in push order.
  class quat_scoreboard;
    quat_t pending[$];
    int    errors;

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
    endfunction

    // keep the whole expression signed so the quotient truncates toward zero
    function automatic logic signed [15:0] frac_div(longint num, longint s);
      return clip16((num * longint'(QOne)) / s);
    endfunction

    function automatic void note_matrix(logic signed [15:0] m[9]);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, rad, s, qtr;
      branch_e br;
      quat_t   q;
      a00 = m[0]; a01 = m[1]; a02 = m[2];
      a10 = m[3]; a11 = m[4]; a12 = m[5];
      a20 = m[6]; a21 = m[7]; a22 = m[8];
      q = '{default: '0};
      rad = a00 + a11 + a22 + QOne;
      if (rad > 0) begin
        br = BrW;
      end else if (a00 > a11 && a00 > a22) begin
        br = BrX; rad = QOne + a00 - a11 - a22;
      end else if (a11 > a22) begin
        br = BrY; rad = QOne + a11 - a00 - a22;
      end else begin
        br = BrZ; rad = QOne + a22 - a00 - a11;
      end
      if (rad <= 0) begin
        q.bad = 1'b1;
      end else begin
        s = longint'(int_sqrt(longint'(rad) * 65536));
        qtr = s / 4;
        case (br)
          BrW: begin
            q.qx = frac_div(a12 - a21, s); q.qy = frac_div(a20 - a02, s);
            q.qz = frac_div(a01 - a10, s); q.qw = clip16(qtr);
          end
          BrX: begin
            q.qx = clip16(qtr);            q.qy = frac_div(a10 + a01, s);
            q.qz = frac_div(a02 + a20, s); q.qw = frac_div(a12 - a21, s);
          end
          BrY: begin
            q.qx = frac_div(a10 + a01, s); q.qy = clip16(qtr);
            q.qz = frac_div(a21 + a12, s); q.qw = frac_div(a20 - a02, s);
          end
          default: begin
            q.qx = frac_div(a20 + a02, s); q.qy = frac_div(a21 + a12, s);
            q.qz = clip16(qtr);            q.qw = frac_div(a01 - a10, s);
          end
        endcase
      end
      pending.push_back(q);
    endfunction

    function automatic void check_quat(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      exp_q = pending.pop_front();
      if (got.qx !== exp_q.qx) begin
        $error("qx: expected %0d, actual %0d", exp_q.qx, got.qx); errors++;
      end
      if (got.qy !== exp_q.qy) begin
        $error("qy: expected %0d, actual %0d", exp_q.qy, got.qy); errors++;
      end
      if (got.qz !== exp_q.qz) begin
        $error("qz: expected %0d, actual %0d", exp_q.qz, got.qz); errors++;
      end
      if (got.qw !== exp_q.qw) begin
        $error("qw: expected %0d, actual %0d", exp_q.qw, got.qw); errors++;
      end
      if (got.bad !== exp_q.bad) begin
        $error("bad_input: expected %0d, actual %0d", exp_q.bad, got.bad); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [15:0] e_i[9];
  logic signed [15:0] qx_o, qy_o, qz_o, qw_o;
  logic bad_input_o;

  quat_scoreboard sb = new();
  bit    no_idle = 1'b0;   // last part of the run: no gaps on either side
  bit    stim_done = 1'b0;

  initial foreach (e_i[k]) e_i[k] = '0;

  always #10 clk_i = ~clk_i;

  rotation_matrix_to_quaternion_core i_dut (
    .clk_i, .rst_ni, .push, .full,
    .e00_i(e_i[0]), .e01_i(e_i[1]), .e02_i(e_i[2]),
    .e10_i(e_i[3]), .e11_i(e_i[4]), .e12_i(e_i[5]),
    .e20_i(e_i[6]), .e21_i(e_i[7]), .e22_i(e_i[8]),
    .empty, .pop, .qx_o, .qy_o, .qz_o, .qw_o, .bad_input_o
  );

  // Drive one matrix word and hold it until the block takes it. Push stays
  // high across back-to-back words; the task only drops it for an idle burst.
  task automatic push_matrix(logic signed [15:0] m[9]);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push <= 1'b1;
    foreach (m[k]) e_i[k] <= m[k];
    do @(posedge clk_i); while (full);
    sb.note_matrix(m);
  endtask

  task automatic push_fields(int v0, int v1, int v2, int v3, int v4,
                             int v5, int v6, int v7, int v8);
    logic signed [15:0] m[9];
    m = '{v0[15:0], v1[15:0], v2[15:0], v3[15:0], v4[15:0],
          v5[15:0], v6[15:0], v7[15:0], v8[15:0]};
    push_matrix(m);
  endtask

  function automatic logic signed [15:0] rand_entry(int mode);
    case (mode)
      0: return 16'($urandom());                             // full range
      1: return 16'($signed($urandom_range(0, 32768)) - 16384); // unit range
      default: return 16'($signed($urandom_range(0, 800)) - 400);
    endcase
  endfunction

  // Random matrices: full-range entries to cover every bit and saturation,
  // unit-range entries, or a random branch with a dominant diagonal.
  task automatic push_random();
    logic signed [15:0] m[9];
    int mode, dom;
    mode = $urandom_range(0, 3);
    foreach (m[k]) m[k] = rand_entry(mode == 0 ? 0 : 1);
    if (mode >= 2) begin
      dom = $urandom_range(0, 3);
      m[0] = -16'sd16384 + rand_entry(2);
      m[4] = -16'sd16384 + rand_entry(2);
      m[8] = -16'sd16384 + rand_entry(2);
      if (dom < 3) m[dom * 4] = 16'sd16384 + rand_entry(2) - 16'sd400;
      if (mode == 3) begin
        // ties on the diagonal exercise branch selection
        m[4] = m[0]; if ($urandom_range(0, 1)) m[8] = m[0];
      end
    end
    push_matrix(m);
  endtask

  // Pop side: random stall bursts, none in the last part.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty)
        sb.check_quat('{qx_o, qy_o, qz_o, qw_o, bad_input_o});
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // identity, half turns about each axis, extremes, non-positive radicands
    push_fields(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    push_fields(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    push_fields(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    push_fields(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    push_fields(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
    push_fields(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    push_fields(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                -32768);
    push_fields(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
    push_fields(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768);
    push_fields(-8192, 0, 0, 0, -8192, 0, 0, 0, 0);        // trace radicand zero
    push_fields(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384); // z branch, tie
    push_fields(-5462, 0, 0, 0, -5461, 0, 0, 0, -5461);    // trace radicand zero, z branch
    push_fields(-16384, 5, 0, 7, -16384, 0, 0, 0, -16384);
    push_fields(-200, 32767, -32768, -32768, -300, 32767, 32767, -32768, -16000);
    push_fields(0, 0, 0, 0, -16384, 0, 0, 0, -16384);      // x branch
    push_fields(-16384, 0, 0, 0, 0, 32767, 0, 32767, -16384);
    push_fields(-16384, 32767, 32767, -32768, -16384, 0, -32768, 0, 0);
    for (int n = 0; n < 700; n++) push_random();
    // hold off until every expected word has been popped
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 500; n++) push_random();
    no_idle = 1'b1;
    for (int n = 0; n < 250; n++) push_random();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS rotation_matrix_to_quaternion_core");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion_core");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL rotation_matrix_to_quaternion_core");
    $finish;
  end

endmodule
`default_nettype wire
